/* sv/cdu_pkg.sv */
// Shared types and constants for the Cholesky decomposition unit.
`timescale 1ns / 1ps
package cdu_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int SIZE_W        = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef struct packed {
    logic [2:0]               row_index;
    logic [2:0]               col_index;
    logic signed [WORD_W-1:0] element_value;
    logic                     load_done;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               out_row;
    logic [2:0]               out_col;
    logic signed [WORD_W-1:0] factor_value;
    logic                     last_of_run;
    logic                     not_pos_definite;
  } out_word_t;

endpackage

/* sv/cdu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/cholesky_decomposition_unit.sv */
// Top level of the Cholesky decomposition unit: loader, sequencer and shared datapath.
`timescale 1ns / 1ps
// Usage:
//   Load the lower triangle of a symmetric matrix on the in_ channel, one word per
//   element (row, column, Q15.16 value). A word with load_done set stores its element
//   and starts the factorization of the leading size_in_use x size_in_use matrix.
//   in_ready is high only while the unit is idle, when it takes one word per cycle.
//   The run first copies the loaded triangle into a work RAM, then walks the
//   columns: pivot read, restoring square root and write-back, one restoring
//   divide per element below the pivot, and three reads, a multiply and a
//   write-back per trailing-triangle element. The root and divide units are
//   bit-serial. Results then leave on the out_ channel in row order, last_of_run
//   marking the final one; each word is read from the work RAM only after the
//   one before it has been taken. A non-positive pivot ends the run with a single
//   word carrying not_pos_definite. A stalled receiver holds the output word and
//   the sequencer waits. The cfg_ channel writes size_in_use and is taken only
//   while idle. Reset returns to idle with size_in_use = 8; the loaded triangle is
//   undefined until written and is kept across runs.
module cholesky_decomposition_unit #(
  parameter int MAX_ORDER = cdu_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = cdu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cdu_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cdu_pkg::out_word_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdu_pkg::SIZE_W-1:0]      cfg_data
);

  import cdu_pkg::*;

  // Sizes derived from the order and fraction width.
  localparam int DEPTH    = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CPY_W    = $clog2(DEPTH + 1);
  localparam int CNT_W    = $clog2(MAX_ORDER + 1);
  localparam int SQ_W     = 2 * ((WORD_W + FRAC_BITS) / 2);
  localparam int SQ_ITER  = SQ_W / 2;
  localparam int NUM_W    = WORD_W + FRAC_BITS;
  localparam int IT_W     = $clog2(NUM_W);

  localparam logic signed [63:0] S64_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S64_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] RND    = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  typedef enum logic [17:0] {
    S_IDLE = 18'b000000000000000001,
    S_COPY = 18'b000000000000000010,
    S_PR   = 18'b000000000000000100,
    S_PC   = 18'b000000000000001000,
    S_SQ   = 18'b000000000000010000,
    S_SW   = 18'b000000000000100000,
    S_DR   = 18'b000000000001000000,
    S_DS   = 18'b000000000010000000,
    S_DIV  = 18'b000000000100000000,
    S_DW   = 18'b000000001000000000,
    S_UA   = 18'b000000010000000000,
    S_UB   = 18'b000000100000000000,
    S_UC   = 18'b000001000000000000,
    S_UM   = 18'b000010000000000000,
    S_UW   = 18'b000100000000000000,
    S_OR   = 18'b001000000000000000,
    S_OV   = 18'b010000000000000000,
    S_OW   = 18'b100000000000000000
  } state_t;

  function automatic logic [ADDR_W-1:0] tri_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
    logic [2*CNT_W+1:0] base;
    base = ({{(CNT_W+2){1'b0}}, r} * ({{(CNT_W+2){1'b0}}, r} + 1'b1)) >> 1;
    return ADDR_W'(base + {{(CNT_W+2){1'b0}}, c});
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > S64_MAX) return S64_MAX[WORD_W-1:0];
    if (v < S64_MIN) return S64_MIN[WORD_W-1:0];
    return v[WORD_W-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [SIZE_W-1:0]        size_r, size_nxt;
  logic [CPY_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         j_r, j_nxt, i_r, i_nxt, k_r, k_nxt;
  logic signed [WORD_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic [WORD_W-1:0]        root_r, root_nxt;
  logic [SQ_W-1:0]          x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [IT_W-1:0]          it_r, it_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt, q_r, q_nxt;
  logic [WORD_W-1:0]        rem_r, rem_nxt;
  logic                     neg_r, neg_nxt;
  out_word_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]  n_w;
  logic              in_acc, in_keep;
  logic [CNT_W-1:0]  in_r_w, in_c_w;

  logic                     s_we;
  logic [ADDR_W-1:0]        s_waddr, s_raddr;
  logic [WORD_W-1:0]        s_rdata;
  logic                     w_we;
  logic [ADDR_W-1:0]        w_waddr, w_raddr;
  logic [WORD_W-1:0]        w_wdata, w_rdata;

  // Clamp the configured order into 1..MAX_ORDER.
  always_comb begin
    if (size_r == '0) begin
      n_w = CNT_W'(1);
    end else if (int'(size_r) > MAX_ORDER) begin
      n_w = CNT_W'(MAX_ORDER);
    end else begin
      n_w = CNT_W'(size_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_r_w    = CNT_W'(in_data.row_index);
  assign in_c_w    = CNT_W'(in_data.col_index);
  assign in_keep   = (in_data.col_index <= in_data.row_index) &&
                     (int'(in_data.row_index) < MAX_ORDER);

  // Loaded triangle: written by the loader, swept into the work RAM at run start.
  assign s_we    = in_acc && in_keep;
  assign s_waddr = tri_addr(in_r_w, in_c_w);
  assign s_raddr = cnt_r[ADDR_W-1:0];

  cdu_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (in_data.element_value),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  cdu_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_work (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Shared datapath scratch values.
  logic [SQ_W-1:0]         sq_t;
  logic [WORD_W:0]         dv_sh;
  logic signed [63:0]      pq, diff;
  logic [WORD_W-1:0]       mag;
  logic signed [WORD_W-1:0] dq;

  always_comb begin
    sq_t  = res_r + bit_r;
    dv_sh = {rem_r, num_r[NUM_W-1]};
    pq    = (prod_r < 0) ? ((prod_r + RND) >>> FRAC_BITS) : (prod_r >>> FRAC_BITS);
    diff  = {{32{c_r[WORD_W-1]}}, c_r} - pq;
    mag   = w_rdata[WORD_W-1] ? (~w_rdata + 1'b1) : w_rdata;
    if (!neg_r) begin
      dq = (q_r > NUM_W'(S64_MAX[WORD_W-1:0])) ? S64_MAX[WORD_W-1:0]
                                                  : q_r[WORD_W-1:0];
    end else begin
      dq = (q_r > NUM_W'({1'b1, {(WORD_W-1){1'b0}}})) ? S64_MIN[WORD_W-1:0]
                                                       : (~q_r[WORD_W-1:0] + 1'b1);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    prod_nxt      = prod_r;
    root_nxt      = root_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    it_nxt        = it_r;
    num_nxt       = num_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    w_we          = 1'b0;
    w_waddr       = tri_addr(i_r, j_r);
    w_wdata       = s_rdata;
    w_raddr       = tri_addr(i_r, j_r);

    if (cfg_valid && cfg_ready) begin
      size_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.load_done) begin
          cnt_nxt   = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // Write lags read by one address: write the entry fetched last cycle.
        w_we    = (cnt_r != '0);
        w_waddr = ADDR_W'(cnt_r - 1'b1);
        w_wdata = s_rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (int'(cnt_r) == DEPTH) begin
          j_nxt     = '0;
          state_nxt = S_PR;
        end
      end
      S_PR: begin
        w_raddr   = tri_addr(j_r, j_r);
        state_nxt = S_PC;
      end
      S_PC: begin
        if ($signed(w_rdata) <= 0) begin
          out_nxt.out_row          = 3'(j_r);
          out_nxt.out_col          = 3'(j_r);
          out_nxt.factor_value     = '0;
          out_nxt.last_of_run      = 1'b1;
          out_nxt.not_pos_definite = 1'b1;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_OW;
        end else begin
          x_nxt     = SQ_W'(w_rdata) << FRAC_BITS;
          res_nxt   = '0;
          bit_nxt   = SQ_W'(1) << (SQ_W - 2);
          it_nxt    = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (x_r >= sq_t) begin
          x_nxt   = x_r - sq_t;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 1'b1;
        if (int'(it_r) == SQ_ITER - 1) begin
          state_nxt = S_SW;
        end
      end
      S_SW: begin
        root_nxt = res_r[WORD_W-1:0];
        w_we     = 1'b1;
        w_waddr  = tri_addr(j_r, j_r);
        w_wdata  = res_r[WORD_W-1:0];
        i_nxt    = j_r + 1'b1;
        if (j_r + 1'b1 < n_w) begin
          state_nxt = S_DR;
        end else begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_OR;
        end
      end
      S_DR: begin
        w_raddr   = tri_addr(i_r, j_r);
        state_nxt = S_DS;
      end
      S_DS: begin
        neg_nxt   = w_rdata[WORD_W-1];
        num_nxt   = {mag, {FRAC_BITS{1'b0}}};
        rem_nxt   = '0;
        q_nxt     = '0;
        it_nxt    = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dv_sh >= {1'b0, root_r}) begin
          rem_nxt = WORD_W'(dv_sh - {1'b0, root_r});
          q_nxt   = {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = dv_sh[WORD_W-1:0];
          q_nxt   = {q_r[NUM_W-2:0], 1'b0};
        end
        num_nxt = num_r << 1;
        it_nxt  = it_r + 1'b1;
        if (int'(it_r) == NUM_W - 1) begin
          state_nxt = S_DW;
        end
      end
      S_DW: begin
        w_we    = 1'b1;
        w_waddr = tri_addr(i_r, j_r);
        w_wdata = dq;
        i_nxt   = i_r + 1'b1;
        if (i_r + 1'b1 < n_w) begin
          state_nxt = S_DR;
        end else begin
          i_nxt     = j_r + 1'b1;
          k_nxt     = j_r + 1'b1;
          state_nxt = S_UA;
        end
      end
      S_UA: begin
        w_raddr   = tri_addr(i_r, j_r);
        state_nxt = S_UB;
      end
      S_UB: begin
        w_raddr   = tri_addr(k_r, j_r);
        a_nxt     = w_rdata;
        state_nxt = S_UC;
      end
      S_UC: begin
        w_raddr   = tri_addr(i_r, k_r);
        b_nxt     = w_rdata;
        state_nxt = S_UM;
      end
      S_UM: begin
        c_nxt     = w_rdata;
        prod_nxt  = 64'(a_r) * 64'(b_r);
        state_nxt = S_UW;
      end
      S_UW: begin
        w_we    = 1'b1;
        w_waddr = tri_addr(i_r, k_r);
        w_wdata = sat32(diff);
        // Advance k within the row, then the row, then the column.
        state_nxt = S_UA;
        if (k_r < i_r) begin
          k_nxt = k_r + 1'b1;
        end else if (i_r + 1'b1 < n_w) begin
          i_nxt = i_r + 1'b1;
          k_nxt = j_r + 1'b1;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PR;
        end
      end
      S_OR: begin
        w_raddr   = tri_addr(i_r, k_r);
        state_nxt = S_OV;
      end
      S_OV: begin
        out_nxt.out_row          = 3'(i_r);
        out_nxt.out_col          = 3'(k_r);
        out_nxt.factor_value     = w_rdata;
        out_nxt.last_of_run      = (i_r == n_w - 1'b1) && (k_r == i_r);
        out_nxt.not_pos_definite = 1'b0;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_OW;
      end
      S_OW: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_of_run) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OR;
            if (k_r < i_r) begin
              k_nxt = k_r + 1'b1;
            end else begin
              i_nxt = i_r + 1'b1;
              k_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r  <= cnt_nxt;
    j_r    <= j_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    prod_r <= prod_nxt;
    root_r <= root_nxt;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    it_r   <= it_nxt;
    num_r  <= num_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A final word starting the run moves straight into the copy sweep.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.load_done |=> state_r == S_COPY)
    else $error("run did not start on load_done");

  // No new input while a result word is pending.
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready)
    else $error("input taken while result pending");

  // An error word always closes the run.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.not_pos_definite |-> out_r.last_of_run)
    else $error("error word without last");

  // Delivering the last word returns the unit to idle.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_r.last_of_run |=> state_r == S_IDLE && !out_valid_r)
    else $error("unit not idle after last word");

endmodule
